>>> hdl/boundary_tag_first_fit_allocator_core_defines.svh
// Assertion macros for the allocator RTL.
`ifndef BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_CORE_DEFINES_SVH
`define BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define BTFF_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BTFF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BTFF_ASSERT_IMPL(label, ante, cons)
`define BTFF_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> hdl/btff_pkg.sv
package btff_pkg;

    localparam int DEF_HEAP_BYTES = 65536;
    localparam int HEAP_START     = 16;
    localparam int CHUNK_BYTES    = 1 << 12;
    localparam int MIN_BLOCK      = 2 * 16;
    localparam int REQ_W          = 17;
    localparam int NEED_W         = 18;
    localparam int ADDR_W         = 16;

    localparam logic       KIND_ALLOC = 1'b0;
    localparam logic       KIND_FREE  = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NULL = 2'd1;
    localparam logic [1:0] ST_OOM  = 2'd2;

endpackage

>>> hdl/btff_tag_ram.sv
module btff_tag_ram #(
    parameter int IW = 13,
    parameter int TW = 18
) (
    input  logic          clk,
    input  logic          we,
    input  logic [IW-1:0] waddr,
    input  logic [TW-1:0] wdata,
    input  logic          re,
    input  logic [IW-1:0] raddr,
    output logic [TW-1:0] rdata
);

    logic [TW-1:0] mem [2**IW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hdl/boundary_tag_first_fit_allocator_core.sv
// Boundary-tag heap allocator with a first-fit walk over an implicit block list. After reset
// the tag memory is initialized by a pass over its HEAP_BYTES/8 entries (8192 at the default
// size) during which busy stays high. A command is taken when start is high and busy is low;
// the single result appears for one cycle with done high and cannot be stalled. Counted from
// the accepting edge, a zero-size allocate returns on the next cycle. A free rewrites the
// block's header and footer, then merges it with free neighbors. An allocate walks the blocks
// one by one and carves the first block that fits, or grows the heap and merges first, or
// returns OOM when it cannot grow. Every tag access goes through the single read port.
`include "boundary_tag_first_fit_allocator_core_defines.svh"

module boundary_tag_first_fit_allocator_core
    import btff_pkg::*;
#(
    parameter int HEAP_BYTES = DEF_HEAP_BYTES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              kind,
    input  logic [REQ_W-1:0]  request_size,
    input  logic [ADDR_W-1:0] block_addr,
    output logic              done,
    output logic [ADDR_W-1:0] payload_addr,
    output logic [1:0]        status
);

    localparam int HB_W = $clog2(HEAP_BYTES);
    localparam int IW   = HB_W - 3;
    localparam int TW   = HB_W + 2;
    localparam int PW   = (HB_W > ADDR_W) ? HB_W : ADDR_W;
    localparam int AW   = PW + 2;
    localparam int CW   = (TW > NEED_W) ? TW : NEED_W;
    localparam int EW   = ((HB_W + 1 > REQ_W) ? HB_W + 1 : REQ_W) + 1;
    localparam int NBW  = $clog2(HEAP_BYTES / 16) + 1;
    localparam int HEW  = HB_W + 1;

    typedef enum logic [5:0] {
        S_CLEAR, S_IDLE,
        S_FREE_RD, S_FREE_HDR, S_FREE_FTR,
        S_WALK_RD, S_WALK_CHK,
        S_GROW_HDR, S_GROW_FTR, S_GROW_EPI,
        S_M_RD_F, S_M_RD_PH, S_M_RD_PF, S_M_RD_H, S_M_RD_NH, S_M_DEC,
        S_M_PU_H, S_M_PU_F,
        S_M_NU_F, S_M_RR_F, S_M_NU_PH,
        S_M_B_D, S_M_B_RH, S_M_B_RNH, S_M_B_F,
        S_M_RET, S_M_RET_D,
        S_CV_RD, S_CV_LD, S_CV_HDR, S_CV_FTR, S_CV_NHDR, S_CV_NFTR
    } state_t;

    state_t              state_reg, state_next;
    logic [IW-1:0]       clr_reg, clr_next;
    logic                kind_reg, kind_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [NEED_W-1:0]   need_reg, need_next;
    logic [AW-1:0]       p_reg, p_next;
    logic [AW-1:0]       pp_reg, pp_next;
    logic [AW-1:0]       np_reg, np_next;
    logic [TW-1:0]       hsz_reg, hsz_next;
    logic [TW-1:0]       phsz_reg, phsz_next;
    logic [TW-1:0]       s_reg, s_next;
    logic [TW-1:0]       c_reg, c_next;
    logic                pu_reg, pu_next;
    logic                split_reg, split_next;
    logic [NBW-1:0]      n_reg, n_next;
    logic [HEW-1:0]      heap_end_reg, heap_end_next;
    logic                done_reg, done_next;
    logic [ADDR_W-1:0]   payload_reg, payload_next;
    logic [1:0]          status_reg, status_next;

    logic                mem_we, mem_re;
    logic [AW-1:0]       mem_wa, mem_ra;
    logic [TW-1:0]       mem_wd, rdata;

    logic [NEED_W-1:0]   ext;
    logic                oom;
    logic [TW-1:0]       rsz;
    logic [NEED_W-1:0]   need_in;

    function automatic logic [TW-1:0] tsz(input logic [TW-1:0] t);
        return {t[TW-1:4], 4'b0000};
    endfunction

    function automatic logic [AW-1:0] ax(input logic [TW-1:0] t);
        return AW'(t);
    endfunction

    function automatic logic [IW-1:0] tag_idx(input logic [AW-1:0] a);
        return a[HB_W-1:3];
    endfunction

    function automatic logic [TW-1:0] init_tag(input logic [IW-1:0] i);
        logic [TW-1:0] v;
        v = '0;
        if (i == IW'(1) || i == IW'(2))
        begin
            v = TW'(17);
        end
        else if (i == IW'(3) || i == IW'(CHUNK_BYTES / 8 + 2))
        begin
            v = TW'(CHUNK_BYTES);
        end
        else if (i == IW'(CHUNK_BYTES / 8 + 3))
        begin
            v = TW'(1);
        end
        return v;
    endfunction

    btff_tag_ram #(
        .IW (IW),
        .TW (TW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_we && state_reg == S_CLEAR ? clr_reg : tag_idx(mem_wa)),
        .wdata (mem_wd),
        .re    (mem_re),
        .raddr (tag_idx(mem_ra)),
        .rdata (rdata)
    );

    assign rsz = tsz(rdata);
    assign ext = (need_reg > NEED_W'(CHUNK_BYTES)) ? need_reg : NEED_W'(CHUNK_BYTES);
    assign oom = (EW'(heap_end_reg) + EW'(ext)) > EW'(HEAP_BYTES);
    assign need_in = (request_size <= REQ_W'(16)) ? NEED_W'(MIN_BLOCK)
                   : ((NEED_W'(request_size) + NEED_W'(31)) & ~NEED_W'(15));

    always_comb
    begin
        logic          split;
        logic [TW-1:0] s3;
        split         = 1'b0;
        s3            = '0;
        state_next    = state_reg;
        clr_next      = clr_reg;
        kind_next     = kind_reg;
        addr_next     = addr_reg;
        need_next     = need_reg;
        p_next        = p_reg;
        pp_next       = pp_reg;
        np_next       = np_reg;
        hsz_next      = hsz_reg;
        phsz_next     = phsz_reg;
        s_next        = s_reg;
        c_next        = c_reg;
        pu_next       = pu_reg;
        split_next    = split_reg;
        n_next        = n_reg;
        heap_end_next = heap_end_reg;
        done_next     = 1'b0;
        payload_next  = payload_reg;
        status_next   = status_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_wa        = '0;
        mem_ra        = '0;
        mem_wd        = '0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wd = init_tag(clr_reg);
                clr_next = clr_reg + IW'(1);
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next = kind;
                    addr_next = block_addr;
                    if (kind == KIND_FREE)
                    begin
                        p_next     = AW'(block_addr);
                        state_next = S_FREE_RD;
                    end
                    else if (request_size == '0)
                    begin
                        done_next    = 1'b1;
                        payload_next = '0;
                        status_next  = ST_NULL;
                    end
                    else
                    begin
                        need_next  = need_in;
                        p_next     = AW'(HEAP_START);
                        n_next     = '0;
                        state_next = S_WALK_RD;
                    end
                end
            end
            S_FREE_RD:
            begin
                mem_re     = 1'b1;
                mem_ra     = p_reg - AW'(8);
                state_next = S_FREE_HDR;
            end
            S_FREE_HDR:
            begin
                mem_we     = 1'b1;
                mem_wa     = p_reg - AW'(8);
                mem_wd     = rsz;
                s_next     = rsz;
                state_next = S_FREE_FTR;
            end
            S_FREE_FTR:
            begin
                mem_we     = 1'b1;
                mem_wa     = p_reg + ax(s_reg) - AW'(16);
                mem_wd     = s_reg;
                state_next = S_M_RD_F;
            end
            S_WALK_RD:
            begin
                if (n_reg == NBW'(HEAP_BYTES / 16))
                begin
                    if (oom)
                    begin
                        done_next    = 1'b1;
                        payload_next = '0;
                        status_next  = ST_OOM;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        s_next     = TW'(ext);
                        p_next     = AW'(heap_end_reg);
                        state_next = S_GROW_HDR;
                    end
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_ra     = p_reg - AW'(8);
                    state_next = S_WALK_CHK;
                end
            end
            S_WALK_CHK:
            begin
                if (rsz == '0)
                begin
                    if (oom)
                    begin
                        done_next    = 1'b1;
                        payload_next = '0;
                        status_next  = ST_OOM;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        s_next     = TW'(ext);
                        p_next     = AW'(heap_end_reg);
                        state_next = S_GROW_HDR;
                    end
                end
                else if (!rdata[0] && CW'(need_reg) <= CW'(rsz))
                begin
                    c_next     = rsz;
                    state_next = S_CV_HDR;
                end
                else
                begin
                    p_next     = p_reg + ax(rsz);
                    n_next     = n_reg + NBW'(1);
                    state_next = S_WALK_RD;
                end
            end
            S_GROW_HDR:
            begin
                mem_we     = 1'b1;
                mem_wa     = p_reg - AW'(8);
                mem_wd     = s_reg;
                state_next = S_GROW_FTR;
            end
            S_GROW_FTR:
            begin
                mem_we     = 1'b1;
                mem_wa     = p_reg + ax(s_reg) - AW'(16);
                mem_wd     = s_reg;
                state_next = S_GROW_EPI;
            end
            S_GROW_EPI:
            begin
                mem_we        = 1'b1;
                mem_wa        = p_reg + ax(s_reg) - AW'(8);
                mem_wd        = TW'(1);
                heap_end_next = heap_end_reg + HEW'(s_reg);
                state_next    = S_M_RD_F;
            end
            // Merge: gather the neighbor tags first, then write back by case.
            S_M_RD_F:
            begin
                mem_re     = 1'b1;
                mem_ra     = p_reg - AW'(16);
                state_next = S_M_RD_PH;
            end
            S_M_RD_PH:
            begin
                pp_next    = p_reg - ax(rsz);
                mem_re     = 1'b1;
                mem_ra     = p_reg - ax(rsz) - AW'(8);
                state_next = S_M_RD_PF;
            end
            S_M_RD_PF:
            begin
                phsz_next  = rsz;
                mem_re     = 1'b1;
                mem_ra     = pp_reg + ax(rsz) - AW'(16);
                state_next = S_M_RD_H;
            end
            S_M_RD_H:
            begin
                pu_next    = rdata[0];
                mem_re     = 1'b1;
                mem_ra     = p_reg - AW'(8);
                state_next = S_M_RD_NH;
            end
            S_M_RD_NH:
            begin
                hsz_next   = rsz;
                np_next    = p_reg + ax(rsz);
                mem_re     = 1'b1;
                mem_ra     = p_reg + ax(rsz) - AW'(8);
                state_next = S_M_DEC;
            end
            S_M_DEC:
            begin
                if (pu_reg && rdata[0])
                begin
                    state_next = kind_reg == KIND_FREE ? S_IDLE : S_CV_RD;
                    if (kind_reg == KIND_FREE)
                    begin
                        done_next    = 1'b1;
                        payload_next = addr_reg;
                        status_next  = ST_OK;
                    end
                end
                else if (pu_reg)
                begin
                    s_next     = hsz_reg + rsz;
                    state_next = S_M_PU_H;
                end
                else if (rdata[0])
                begin
                    s_next     = hsz_reg + phsz_reg;
                    state_next = S_M_NU_F;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_ra     = np_reg + ax(rsz) - AW'(16);
                    state_next = S_M_B_D;
                end
            end
            S_M_PU_H:
            begin
                mem_we     = 1'b1;
                mem_wa     = p_reg - AW'(8);
                mem_wd     = s_reg;
                state_next = S_M_PU_F;
            end
            S_M_PU_F:
            begin
                mem_we     = 1'b1;
                mem_wa     = p_reg + ax(tsz(s_reg)) - AW'(16);
                mem_wd     = s_reg;
                state_next = kind_reg == KIND_FREE ? S_IDLE : S_CV_RD;
                if (kind_reg == KIND_FREE)
                begin
                    done_next    = 1'b1;
                    payload_next = addr_reg;
                    status_next  = ST_OK;
                end
            end
            S_M_NU_F:
            begin
                mem_we     = 1'b1;
                mem_wa     = p_reg + ax(hsz_reg) - AW'(16);
                mem_wd     = s_reg;
                state_next = S_M_RR_F;
            end
            S_M_RR_F:
            begin
                mem_re     = 1'b1;
                mem_ra     = p_reg - AW'(16);
                state_next = S_M_NU_PH;
            end
            S_M_NU_PH:
            begin
                mem_we     = 1'b1;
                mem_wa     = p_reg - ax(rsz) - AW'(8);
                mem_wd     = s_reg;
                state_next = S_M_RET;
            end
            S_M_B_D:
            begin
                s3         = hsz_reg + phsz_reg + rsz;
                s_next     = s3;
                mem_we     = 1'b1;
                mem_wa     = pp_reg - AW'(8);
                mem_wd     = s3;
                state_next = S_M_B_RH;
            end
            S_M_B_RH:
            begin
                mem_re     = 1'b1;
                mem_ra     = p_reg - AW'(8);
                state_next = S_M_B_RNH;
            end
            S_M_B_RNH:
            begin
                np_next    = p_reg + ax(rsz);
                mem_re     = 1'b1;
                mem_ra     = p_reg + ax(rsz) - AW'(8);
                state_next = S_M_B_F;
            end
            S_M_B_F:
            begin
                mem_we     = 1'b1;
                mem_wa     = np_reg + ax(rsz) - AW'(16);
                mem_wd     = s_reg;
                state_next = S_M_RET;
            end
            S_M_RET:
            begin
                mem_re     = 1'b1;
                mem_ra     = p_reg - AW'(16);
                state_next = S_M_RET_D;
            end
            S_M_RET_D:
            begin
                p_next     = p_reg - ax(rsz);
                state_next = kind_reg == KIND_FREE ? S_IDLE : S_CV_RD;
                if (kind_reg == KIND_FREE)
                begin
                    done_next    = 1'b1;
                    payload_next = addr_reg;
                    status_next  = ST_OK;
                end
            end
            S_CV_RD:
            begin
                mem_re     = 1'b1;
                mem_ra     = p_reg - AW'(8);
                state_next = S_CV_LD;
            end
            S_CV_LD:
            begin
                c_next     = rsz;
                state_next = S_CV_HDR;
            end
            S_CV_HDR:
            begin
                split = (CW'(c_reg) >= CW'(need_reg))
                     && (CW'(c_reg) - CW'(need_reg) >= CW'(MIN_BLOCK));
                split_next = split;
                mem_we     = 1'b1;
                mem_wa     = p_reg - AW'(8);
                mem_wd     = split ? (TW'(need_reg) | TW'(1)) : (c_reg | TW'(1));
                state_next = S_CV_FTR;
            end
            S_CV_FTR:
            begin
                mem_we = 1'b1;
                mem_wa = split_reg ? p_reg + AW'(need_reg) - AW'(16)
                                   : p_reg + ax(c_reg) - AW'(16);
                mem_wd = split_reg ? (TW'(need_reg) | TW'(1)) : (c_reg | TW'(1));
                if (split_reg)
                begin
                    state_next = S_CV_NHDR;
                end
                else
                begin
                    done_next    = 1'b1;
                    payload_next = p_reg[ADDR_W-1:0];
                    status_next  = ST_OK;
                    state_next   = S_IDLE;
                end
            end
            S_CV_NHDR:
            begin
                // Remainder header here; its footer shares the old footer slot.
                mem_we     = 1'b1;
                mem_wa     = p_reg + AW'(need_reg) - AW'(8);
                mem_wd     = c_reg - TW'(need_reg);
                state_next = S_CV_NFTR;
            end
            S_CV_NFTR:
            begin
                mem_we       = 1'b1;
                mem_wa       = p_reg + ax(c_reg) - AW'(16);
                mem_wd       = c_reg - TW'(need_reg);
                done_next    = 1'b1;
                payload_next = p_reg[ADDR_W-1:0];
                status_next  = ST_OK;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            heap_end_reg <= HEW'(CHUNK_BYTES + 32);
            done_reg     <= 1'b0;
            payload_reg  <= '0;
            status_reg   <= ST_OK;
            kind_reg     <= KIND_ALLOC;
            pu_reg       <= 1'b0;
            split_reg    <= 1'b0;
            n_reg        <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            heap_end_reg <= heap_end_next;
            done_reg     <= done_next;
            payload_reg  <= payload_next;
            status_reg   <= status_next;
            kind_reg     <= kind_next;
            pu_reg       <= pu_next;
            split_reg    <= split_next;
            n_reg        <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        need_reg <= need_next;
        p_reg    <= p_next;
        pp_reg   <= pp_next;
        np_reg   <= np_next;
        hsz_reg  <= hsz_next;
        phsz_reg <= phsz_next;
        s_reg    <= s_next;
        c_reg    <= c_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign payload_addr = payload_reg;
    assign status       = status_reg;

    `BTFF_ASSERT_IMPL(a_err_null_addr, done_reg && status_reg != ST_OK, payload_reg == '0)
    `BTFF_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done_reg)
    `BTFF_ASSERT_IMPL(a_heap_end_limit, 1'b1, heap_end_reg <= HEW'(HEAP_BYTES))
    `BTFF_ASSERT_IMPL(a_walk_bound, state_reg == S_WALK_CHK, n_reg < NBW'(HEAP_BYTES / 16))

endmodule
